FILE: rtl/i2a_pkg.sv
// shared types, codes and character constants for the integer to ascii formatter
package i2a_pkg;

  // format codes
  localparam logic [1:0] FUNC_UDEC = 2'd0;
  localparam logic [1:0] FUNC_SDEC = 2'd1;
  localparam logic [1:0] FUNC_HEX  = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  // ascii codes
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A     = 7'h41;
  localparam logic [6:0] CH_MINUS = 7'h2d;

  // input beat
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] value;
    logic [5:0]  hex_bits;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [6:0] character;
    logic       last_char;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic dabble;
    logic skip;
    logic emit_dec;
    logic emit_hex;
    logic emit_sign;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic conv_last;
    logic skip_ok;
    logic one_left;
    logic none_left;
    logic neg;
  } sts_t;

  // upper-case hex digit for one nibble
  function automatic logic [6:0] nib_char(input logic [3:0] n);
    logic [6:0] c;
    if (n < 4'd10) begin
      c = CH_ZERO + {3'b000, n};
    end else begin
      c = CH_A + {3'b000, n - 4'd10};
    end
    return c;
  endfunction

endpackage

FILE: rtl/i2a_ctrl.sv
// controller state machine for the integer to ascii formatter
module i2a_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      func,
  input  i2a_pkg::sts_t   sts,
  output i2a_pkg::cmd_t   cmd,
  output logic            busy
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_DEC  = 3'd4;
  localparam logic [2:0] ST_HEX  = 3'd5;

  logic [2:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          priority if (func == i2a_pkg::FUNC_HEX) begin
            cmd.load  = 1'b1;
            state_nxt = ST_HEX;
          end else if (func == i2a_pkg::FUNC_NONE) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        cmd.dabble = 1'b1;
        if (sts.conv_last) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.skip_ok) begin
          cmd.skip = 1'b1;
        end else begin
          state_nxt = sts.neg ? ST_SIGN : ST_DEC;
        end
      end
      ST_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_nxt     = ST_DEC;
      end
      ST_DEC: begin
        cmd.emit_dec = 1'b1;
        if (sts.one_left) state_nxt = ST_IDLE;
      end
      ST_HEX: begin
        if (sts.none_left) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.emit_hex = 1'b1;
          if (sts.one_left) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: rtl/i2a_dp.sv
// datapath: double-dabble converter, digit shifter, hex aligner and output register
module i2a_dp #(
  parameter int VALUE_WIDTH = 32,
  parameter int DEC_DIGITS  = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  i2a_pkg::in_item_t  in_item,
  input  i2a_pkg::cmd_t      cmd,
  output i2a_pkg::sts_t      sts,
  output logic               out_valid,
  output i2a_pkg::out_item_t out_item
);

  localparam int NIB  = (VALUE_WIDTH + 3) / 4;
  localparam int HW   = NIB * 4;
  localparam int BW   = DEC_DIGITS * 4;
  localparam int CMAX = (DEC_DIGITS > NIB) ? DEC_DIGITS : NIB;
  localparam int RW   = $clog2(CMAX + 1);
  localparam int CW   = $clog2(VALUE_WIDTH + 1);
  localparam int SW   = $clog2(HW + 1);

  logic [HW-1:0]      work_r, work_nxt;
  logic [BW-1:0]      bcd_r, bcd_nxt;
  logic               ovf_r, ovf_nxt;
  logic               neg_r, neg_nxt;
  logic [CW-1:0]      bitcnt_r, bitcnt_nxt;
  logic [RW-1:0]      remain_r, remain_nxt;
  logic               out_valid_r;
  i2a_pkg::out_item_t out_r, out_nxt;

  // input value at the configured width
  logic [VALUE_WIDTH+31:0] v_ext;
  logic [VALUE_WIDTH-1:0]  v;
  logic [VALUE_WIDTH-1:0]  mag;
  logic                    is_neg;
  assign v_ext  = {{VALUE_WIDTH{1'b0}}, in_item.value};
  assign v      = v_ext[VALUE_WIDTH-1:0];
  assign is_neg = (in_item.func == i2a_pkg::FUNC_SDEC) && v[VALUE_WIDTH-1];
  assign mag    = is_neg ? (~v + 1'b1) : v;

  // hex width saturation, masking and alignment of the top nibble
  logic [6:0]             bits_sat;
  logic [RW-1:0]          nib_cnt;
  logic [VALUE_WIDTH-1:0] hex_masked;
  logic [SW-1:0]          hex_shamt;
  logic [6:0]             nib_round;
  assign bits_sat   = ({1'b0, in_item.hex_bits} > 7'(VALUE_WIDTH)) ?
                      7'(VALUE_WIDTH) : {1'b0, in_item.hex_bits};
  assign nib_round  = bits_sat + 7'd3;
  assign nib_cnt    = RW'(nib_round[6:2]);
  assign hex_masked = v & ~({VALUE_WIDTH{1'b1}} << bits_sat);
  assign hex_shamt  = SW'(HW) - SW'({nib_round[6:2], 2'b00});

  // add-3 correction on every digit before the shift
  logic [BW-1:0] bcd_adj;
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ?
                          bcd_r[i*4 +: 4] + 4'd3 : bcd_r[i*4 +: 4];
    end
  end

  logic [3:0] top_digit;
  assign top_digit = bcd_r[BW-1 -: 4];

  // register updates by command
  always_comb begin
    work_nxt   = work_r;
    bcd_nxt    = bcd_r;
    ovf_nxt    = ovf_r;
    neg_nxt    = neg_r;
    bitcnt_nxt = bitcnt_r;
    remain_nxt = remain_r;
    out_nxt    = out_r;
    if (cmd.load) begin
      if (in_item.func == i2a_pkg::FUNC_HEX) begin
        work_nxt   = HW'(hex_masked) << hex_shamt;
        remain_nxt = nib_cnt;
        neg_nxt    = 1'b0;
      end else begin
        work_nxt   = HW'(mag);
        bcd_nxt    = '0;
        ovf_nxt    = 1'b0;
        neg_nxt    = is_neg;
        bitcnt_nxt = CW'(VALUE_WIDTH);
        remain_nxt = RW'(DEC_DIGITS);
      end
    end
    if (cmd.dabble) begin
      bcd_nxt    = {bcd_adj[BW-2:0], work_r[VALUE_WIDTH-1]};
      ovf_nxt    = ovf_r | bcd_adj[BW-1];
      work_nxt   = work_r << 1;
      bitcnt_nxt = bitcnt_r - 1'b1;
    end
    if (cmd.skip) begin
      bcd_nxt    = bcd_r << 4;
      remain_nxt = remain_r - 1'b1;
    end
    if (cmd.emit_sign) begin
      out_nxt.character = i2a_pkg::CH_MINUS;
      out_nxt.last_char = 1'b0;
    end
    if (cmd.emit_dec) begin
      out_nxt.character = i2a_pkg::CH_ZERO + {3'b000, top_digit};
      out_nxt.last_char = (remain_r == RW'(1));
      bcd_nxt           = bcd_r << 4;
      remain_nxt        = remain_r - 1'b1;
    end
    if (cmd.emit_hex) begin
      out_nxt.character = i2a_pkg::nib_char(work_r[HW-1 -: 4]);
      out_nxt.last_char = (remain_r == RW'(1));
      work_nxt          = work_r << 4;
      remain_nxt        = remain_r - 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    work_r   <= work_nxt;
    bcd_r    <= bcd_nxt;
    ovf_r    <= ovf_nxt;
    neg_r    <= neg_nxt;
    bitcnt_r <= bitcnt_nxt;
    remain_r <= remain_nxt;
    out_r    <= out_nxt;
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_dec | cmd.emit_hex | cmd.emit_sign;
    end
  end

  // status to the controller
  assign sts.conv_last = (bitcnt_r == CW'(1));
  assign sts.skip_ok   = !ovf_r && (top_digit == 4'd0) && (remain_r > RW'(1));
  assign sts.one_left  = (remain_r == RW'(1));
  assign sts.none_left = (remain_r == '0);
  assign sts.neg       = neg_r;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: rtl/integer_to_ascii_formatter_top.sv
// top level of the integer to ascii formatter
//
//  channel | ports                   | handshake
//  --------+-------------------------+--------------------------------------
//  input   | in_item                 | taken when start=1 and busy=0
//  result  | out_item (out_valid)    | one beat per strobe cycle, no stall
//
// decimal: a load, VALUE_WIDTH double-dabble steps, a scan step per dropped
//   leading zero plus one more, then the characters one by one ('-' included)
// hex: a load, then one character per nibble (none when nothing prints)
// format code 3 is taken and dropped with busy never raised
// synchronous active-low reset returns to idle; results cannot be held off
module integer_to_ascii_formatter_top #(
  parameter int VALUE_WIDTH = 32,
  parameter int DEC_DIGITS  = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  i2a_pkg::in_item_t  in_item,
  output logic               out_valid,
  output i2a_pkg::out_item_t out_item
);

  i2a_pkg::cmd_t cmd;
  i2a_pkg::sts_t sts;

  i2a_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_item.func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  i2a_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DEC_DIGITS  (DEC_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/i2a_checker.sv
// port-level checks for the integer to ascii formatter, bound to the top level
module i2a_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input i2a_pkg::in_item_t  in_item,
  input logic               out_valid,
  input i2a_pkg::out_item_t out_item
);

  // a character only follows a busy cycle
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without prior busy cycle");

  // the unused format code never starts work
  a_none_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.func == i2a_pkg::FUNC_NONE) |=> !busy)
    else $error("unused format code raised busy");

  // the final character closes the text
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_char) |=> !out_valid)
    else $error("beat right after final character");

  // zero hex width prints nothing
  a_hex_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.func == i2a_pkg::FUNC_HEX && in_item.hex_bits == 6'd0)
    |=> !out_valid ##1 !out_valid)
    else $error("zero-width hex printed a character");

  // the minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.character == i2a_pkg::CH_MINUS) |-> !out_item.last_char)
    else $error("minus sign flagged as final character");

endmodule

bind integer_to_ascii_formatter_top i2a_checker u_i2a_checker (.*);
